[src/oss_pkg.sv]
// Package for the ordered sequence store: beat structs, command, status and cell op codes.
// Every module of the block imports this package; it depends on nothing else.
`timescale 1ns / 1ps
`default_nettype none

package oss_pkg;

    localparam int CAPACITY_DEF = 64;
    localparam int POS_W        = 7;
    localparam int VAL_W        = 32;
    localparam int STATUS_W     = 2;
    localparam int FPOS_W       = 6;
    localparam int COUNT_W      = 7;

    typedef enum logic [2:0] {
        CMD_APPEND    = 3'd0,
        CMD_INSERT    = 3'd1,
        CMD_REMOVE    = 3'd2,
        CMD_READ      = 3'd3,
        CMD_OVERWRITE = 3'd4,
        CMD_FIND      = 3'd5,
        CMD_REVERSE   = 3'd6,
        CMD_CLEAR     = 3'd7
    } t_cmd;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        OP_HOLD   = 2'd0,
        OP_WRITE  = 2'd1,
        OP_INSERT = 2'd2,
        OP_REMOVE = 2'd3
    } t_cell_op;

    typedef struct packed {
        t_cmd                     command;
        logic [POS_W-1:0]         position;
        logic signed [VAL_W-1:0]  value;
    } t_cmd_beat;

    typedef struct packed {
        t_status                  status;
        logic signed [VAL_W-1:0]  read_value;
        logic                     found;
        logic [FPOS_W-1:0]        found_position;
        logic [COUNT_W-1:0]       count;
    } t_result_beat;

    typedef struct packed {
        t_cell_op                 op;
        logic                     rd_en;
        logic                     fd_en;
        logic signed [VAL_W-1:0]  value;
    } t_cell_ctl;

endpackage

`default_nettype wire

[src/ordered_sequence_store_core.sv]
// Ordered sequence store: a row of element cells that shift on insert and remove.
// An accepted command passes the stage-one register and then the output register before its result strobe.
// Busy is held by the stage-one register, so no new command is taken while one is in stage one.
// Reverse flips a logical order bit, so it takes no longer than any other command.
// Reset clears the count and the order bit; element contents stay undefined, no clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module ordered_sequence_store_core
    import oss_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF
) (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_start,
    input  wire t_cmd_beat i_cmd,
    output logic           o_busy,
    output logic           o_valid,
    output t_result_beat   o_result
);

    localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

    logic                    w_accept;
    logic [CMP_W-1:0]        w_n;
    logic [CMP_W-1:0]        w_p;
    logic [CMP_W-1:0]        w_ins_p;
    logic [CMP_W-1:0]        w_phys;
    logic                    w_full;
    t_cell_ctl               w_ctl;
    t_status                 w_status;
    logic [IDX_W-1:0]        w_idx;

    logic [CNT_W-1:0]        r_count;
    logic [CNT_W-1:0]        n_count;
    logic                    r_flip;
    logic                    n_flip;

    logic                    r_s1_valid;
    t_status                 r_s1_status;
    logic                    r_s1_flip;
    logic [CNT_W-1:0]        r_s1_count;

    logic                    r_out_valid;
    t_result_beat            r_result;

    logic signed [VAL_W-1:0] w_elem [CAPACITY];
    logic [CAPACITY-1:0]     w_sel;
    logic [CAPACITY-1:0]     w_match;
    logic signed [VAL_W-1:0] w_data;
    logic                    w_any;
    logic [IDX_W-1:0]        w_lo;
    logic [IDX_W-1:0]        w_hi;
    logic [CNT_W-1:0]        w_fpos;
    logic [CMP_W-1:0]        w_fpos_ext;
    logic [CMP_W-1:0]        w_count_ext;

    assign o_busy   = r_s1_valid | !i_rst_n;
    assign w_accept = i_start && !o_busy;

    assign w_n    = CMP_W'(r_count);
    assign w_p    = CMP_W'(i_cmd.position);
    assign w_full = (w_n == CMP_W'(CAPACITY));

    always_comb begin
        w_ins_p = (i_cmd.command == CMD_APPEND) ? w_n : w_p;
        w_phys  = r_flip ? (w_n - w_p - CMP_W'(1)) : w_p;
        w_ctl   = '{op: OP_HOLD, rd_en: 1'b0, fd_en: 1'b0, value: i_cmd.value};
        w_idx   = IDX_W'(w_phys);
        w_status = ST_OK;
        n_count = r_count;
        n_flip  = r_flip;
        unique case (i_cmd.command)
            CMD_APPEND, CMD_INSERT: begin
                w_idx = IDX_W'(r_flip ? (w_n - w_ins_p) : w_ins_p);
                if (w_ins_p > w_n) begin
                    w_status = ST_RANGE;
                end else if (w_full) begin
                    w_status = ST_FULL;
                end else begin
                    w_ctl.op = OP_INSERT;
                    n_count  = r_count + CNT_W'(1);
                end
            end
            CMD_REMOVE: begin
                if (w_p >= w_n) begin
                    w_status = ST_RANGE;
                end else begin
                    w_ctl.op = OP_REMOVE;
                    n_count  = r_count - CNT_W'(1);
                end
            end
            CMD_READ: begin
                if (w_p >= w_n) begin
                    w_status = ST_RANGE;
                end else begin
                    w_ctl.rd_en = 1'b1;
                end
            end
            CMD_OVERWRITE: begin
                if (w_p >= w_n) begin
                    w_status = ST_RANGE;
                end else begin
                    w_ctl.op = OP_WRITE;
                end
            end
            CMD_FIND: begin
                w_ctl.fd_en = 1'b1;
            end
            CMD_REVERSE: begin
                n_flip = !r_flip;
            end
            CMD_CLEAR: begin
                n_count = '0;
                n_flip  = 1'b0;
            end
            default: begin
                w_status = ST_OK;
            end
        endcase
    end

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic signed [VAL_W-1:0] w_left;
        logic signed [VAL_W-1:0] w_right;

        if (g == 0) begin : g_first
            assign w_left = '0;
        end else begin : g_mid_l
            assign w_left = w_elem[g-1];
        end
        if (g == CAPACITY - 1) begin : g_last
            assign w_right = '0;
        end else begin : g_mid_r
            assign w_right = w_elem[g+1];
        end

        oss_cell #(
            .IDX_W (IDX_W),
            .CNT_W (CNT_W),
            .IDX   (g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_accept),
            .i_ctl   (w_ctl),
            .i_idx   (w_idx),
            .i_lim   (r_count),
            .i_left  (w_left),
            .i_right (w_right),
            .o_elem  (w_elem[g]),
            .o_sel   (w_sel[g]),
            .o_match (w_match[g])
        );
    end

    oss_reduce #(
        .CAPACITY (CAPACITY),
        .IDX_W    (IDX_W)
    ) u_reduce (
        .i_sel   (w_sel),
        .i_match (w_match),
        .i_elem  (w_elem),
        .o_data  (w_data),
        .o_any   (w_any),
        .o_lo    (w_lo),
        .o_hi    (w_hi)
    );

    assign w_fpos = r_s1_flip ? (r_s1_count - CNT_W'(1) - CNT_W'(w_hi)) : CNT_W'(w_lo);
    assign w_fpos_ext  = w_any ? CMP_W'(w_fpos) : '0;
    assign w_count_ext = CMP_W'(r_s1_count);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_flip      <= 1'b0;
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_s1_valid  <= w_accept;
            r_out_valid <= r_s1_valid;
            if (w_accept) begin
                r_count <= n_count;
                r_flip  <= n_flip;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_s1_status <= w_status;
            r_s1_flip   <= r_flip;
            r_s1_count  <= n_count;
        end
        if (r_s1_valid) begin
            r_result.status         <= r_s1_status;
            r_result.read_value     <= w_data;
            r_result.found          <= w_any;
            r_result.found_position <= w_fpos_ext[FPOS_W-1:0];
            r_result.count          <= w_count_ext[COUNT_W-1:0];
        end
    end

    assign o_valid  = r_out_valid;
    assign o_result = r_result;

endmodule

`default_nettype wire

[src/oss_cell.sv]
// One storage cell of the chain: holds one element and takes its neighbor's on a shift.
// It also flags a positional select and a key match for the reduction stage; uses oss_pkg.
`timescale 1ns / 1ps
`default_nettype none

module oss_cell
    import oss_pkg::*;
#(
    parameter int IDX_W = 6,
    parameter int CNT_W = 7,
    parameter int IDX   = 0
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_en,
    input  wire t_cell_ctl               i_ctl,
    input  wire logic [IDX_W-1:0]        i_idx,
    input  wire logic [CNT_W-1:0]        i_lim,
    input  wire logic signed [VAL_W-1:0] i_left,
    input  wire logic signed [VAL_W-1:0] i_right,
    output logic signed [VAL_W-1:0]      o_elem,
    output logic                         o_sel,
    output logic                         o_match
);

    localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(IDX);
    localparam logic [CNT_W-1:0] MY_CNT = CNT_W'(IDX);

    logic signed [VAL_W-1:0] r_elem;
    logic signed [VAL_W-1:0] n_elem;
    logic                    r_sel;
    logic                    r_match;

    always_comb begin
        n_elem = r_elem;
        unique case (i_ctl.op)
            OP_HOLD: begin
                n_elem = r_elem;
            end
            OP_WRITE: begin
                if (MY_IDX == i_idx) begin
                    n_elem = i_ctl.value;
                end
            end
            OP_INSERT: begin
                if (MY_IDX > i_idx) begin
                    n_elem = i_left;
                end else if (MY_IDX == i_idx) begin
                    n_elem = i_ctl.value;
                end
            end
            OP_REMOVE: begin
                if (MY_IDX >= i_idx) begin
                    n_elem = i_right;
                end
            end
            default: begin
                n_elem = r_elem;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_elem <= n_elem;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sel   <= 1'b0;
            r_match <= 1'b0;
        end else if (i_en) begin
            r_sel   <= i_ctl.rd_en && (MY_IDX == i_idx);
            r_match <= i_ctl.fd_en && (r_elem == i_ctl.value) && (MY_CNT < i_lim);
        end
    end

    assign o_elem  = r_elem;
    assign o_sel   = r_sel;
    assign o_match = r_match;

endmodule

`default_nettype wire

[src/oss_reduce.sv]
// Reduction across the cell row: gathers the selected element and the lowest and highest
// matching cell. Uses oss_pkg for the element width.
`timescale 1ns / 1ps
`default_nettype none

module oss_reduce
    import oss_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF,
    parameter int IDX_W    = 6
) (
    input  wire logic [CAPACITY-1:0]     i_sel,
    input  wire logic [CAPACITY-1:0]     i_match,
    input  wire logic signed [VAL_W-1:0] i_elem [CAPACITY],
    output logic signed [VAL_W-1:0]      o_data,
    output logic                         o_any,
    output logic [IDX_W-1:0]             o_lo,
    output logic [IDX_W-1:0]             o_hi
);

    always_comb begin
        o_data = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            o_data = o_data | (i_elem[i] & {VAL_W{i_sel[i]}});
        end
    end

    always_comb begin
        o_lo = '0;
        for (int i = CAPACITY - 1; i >= 0; i--) begin
            if (i_match[i]) begin
                o_lo = IDX_W'(i);
            end
        end
    end

    always_comb begin
        o_hi = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            if (i_match[i]) begin
                o_hi = IDX_W'(i);
            end
        end
    end

    assign o_any = |i_match;

endmodule

`default_nettype wire

[src/oss_checker.sv]
// Port-level checker for the ordered sequence store, bound to the top level.
// Uses oss_pkg for the beat types and status codes.
`timescale 1ns / 1ps
`default_nettype none

module oss_checker
    import oss_pkg::*;
(
    input wire logic         i_clk,
    input wire logic         i_rst_n,
    input wire logic         i_start,
    input wire t_cmd_beat    i_cmd,
    input wire logic         o_busy,
    input wire logic         o_valid,
    input wire t_result_beat o_result
);

    logic w_acc;

    assign w_acc = i_start && !o_busy;

    a_busy_after_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_acc |=> o_busy)
        else $error("busy not raised after an accepted beat");

    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_acc |-> ##2 o_valid)
        else $error("result strobe missing two cycles after a beat");

    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(w_acc, 2))
        else $error("result strobe without an accepted beat");

    a_single_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("result strobe lasted more than one cycle");

    a_error_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_result.status != ST_OK)) |->
            ((o_result.read_value == '0) && !o_result.found))
        else $error("failed command reported data");

endmodule

bind ordered_sequence_store_core oss_checker u_oss_checker (.*);

`default_nettype wire

[verif/tb.sv]
// Self-checking bench for ordered_sequence_store_core: directed and random command beats.
// A shadow sequence predicts each result beat; depends on oss_pkg and the core.
`timescale 1ns / 1ps

module tb;
    import oss_pkg::*;

    localparam int CAP         = CAPACITY_DEF;
    localparam int CYCLE_LIMIT = 200000;

    logic         i_clk;
    logic         i_rst_n = 1'b0;
    logic         i_start = 1'b0;
    t_cmd_beat    i_cmd   = '0;
    logic         o_busy;
    logic         o_valid;
    t_result_beat o_result;

    ordered_sequence_store_core dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (i_start),
        .i_cmd    (i_cmd),
        .o_busy   (o_busy),
        .o_valid  (o_valid),
        .o_result (o_result)
    );

    t_cmd_beat    pending_cmds[$];
    t_result_beat results_due[$];
    logic [31:0]  seq_mem[CAP];
    int           seq_count     = 0;
    int           planned_count = 0;
    logic [31:0]  value_pool[16];
    logic         took_beat     = 1'b0;
    int           total_items   = 0;
    int           n_accepted    = 0;
    int           n_checked     = 0;
    int           n_range       = 0;
    int           n_full        = 0;
    int           n_hits        = 0;
    int           errors        = 0;
    int           cycles        = 0;

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    function automatic t_result_beat predict_result(t_cmd_beat beat);
        t_result_beat r;
        int           n;
        int           p;
        logic [31:0]  tmp;
        n = seq_count;
        p = int'(beat.position);
        r = '0;
        r.status = ST_OK;
        case (beat.command)
            CMD_APPEND: begin
                if (n >= CAP) begin
                    r.status = ST_FULL;
                end else begin
                    seq_mem[n] = beat.value;
                    n++;
                end
            end
            CMD_INSERT: begin
                if (p > n) begin
                    r.status = ST_RANGE;
                end else if (n >= CAP) begin
                    r.status = ST_FULL;
                end else begin
                    for (int i = n; i > p; i--) seq_mem[i] = seq_mem[i-1];
                    seq_mem[p] = beat.value;
                    n++;
                end
            end
            CMD_REMOVE: begin
                if (p >= n) begin
                    r.status = ST_RANGE;
                end else begin
                    for (int i = p; i + 1 < n; i++) seq_mem[i] = seq_mem[i+1];
                    n--;
                end
            end
            CMD_READ: begin
                if (p >= n) r.status = ST_RANGE;
                else r.read_value = seq_mem[p];
            end
            CMD_OVERWRITE: begin
                if (p >= n) r.status = ST_RANGE;
                else seq_mem[p] = beat.value;
            end
            CMD_FIND: begin
                for (int i = 0; i < n; i++) begin
                    if (!r.found && seq_mem[i] == beat.value) begin
                        r.found = 1'b1;
                        r.found_position = i[5:0];
                    end
                end
            end
            CMD_REVERSE: begin
                for (int i = 0; i < n / 2; i++) begin
                    tmp = seq_mem[i];
                    seq_mem[i] = seq_mem[n-1-i];
                    seq_mem[n-1-i] = tmp;
                end
            end
            CMD_CLEAR: begin
                n = 0;
            end
        endcase
        seq_count = n;
        r.count = n[6:0];
        return r;
    endfunction

    task automatic check_field(string name, logic [31:0] want_v, logic [31:0] got_v);
        if (want_v !== got_v) begin
            $display("t=%0t: %s mismatch, expected %0h, got %0h", $time, name, want_v, got_v);
            errors++;
        end
    endtask

    // Queues one command and tracks the count it will leave behind.
    task automatic add_cmd(t_cmd c, int pos, logic [31:0] v);
        t_cmd_beat beat;
        beat.command = c;
        beat.position = pos[6:0];
        beat.value = v;
        pending_cmds.push_back(beat);
        case (c)
            CMD_APPEND: if (planned_count < CAP) planned_count++;
            CMD_INSERT: if (pos <= planned_count && planned_count < CAP) planned_count++;
            CMD_REMOVE: if (pos < planned_count) planned_count--;
            CMD_CLEAR:  planned_count = 0;
            default: ;
        endcase
    endtask

    function automatic logic [31:0] pick_value();
        if ($urandom_range(0, 9) < 6) return value_pool[$urandom_range(0, 15)];
        return $urandom();
    endfunction

    function automatic int pick_position(t_cmd c);
        if ($urandom_range(0, 9) == 0) return $urandom_range(0, 64);
        if (c == CMD_INSERT) begin
            if ($urandom_range(0, 1) == 1) return planned_count;
            return $urandom_range(0, planned_count);
        end
        if (planned_count > 0) return $urandom_range(0, planned_count - 1);
        return $urandom_range(0, 64);
    endfunction

    always @(posedge i_clk) begin
        t_result_beat want;
        if (i_rst_n) begin
            if (o_valid) begin
                if (results_due.size() == 0) begin
                    $display("t=%0t: result beat with nothing expected, got %0h",
                             $time, o_result);
                    errors++;
                end else begin
                    want = results_due.pop_front();
                    check_field("status", 32'(want.status), 32'(o_result.status));
                    check_field("read_value", want.read_value, o_result.read_value);
                    check_field("found", 32'(want.found), 32'(o_result.found));
                    check_field("found_position", 32'(want.found_position),
                                32'(o_result.found_position));
                    check_field("count", 32'(want.count), 32'(o_result.count));
                    n_checked++;
                end
            end
            if (i_start && !o_busy) begin
                want = predict_result(i_cmd);
                results_due.push_back(want);
                if (want.status == ST_RANGE) n_range++;
                if (want.status == ST_FULL) n_full++;
                if (want.found) n_hits++;
                void'(pending_cmds.pop_front());
                n_accepted++;
                took_beat = 1'b1;
            end else begin
                took_beat = 1'b0;
            end
        end
    end

    always @(negedge i_clk) begin
        int idle_pct;
        if (n_accepted * 3 < total_items) idle_pct = 18;
        else if (n_accepted * 3 < 2 * total_items) idle_pct = 62;
        else idle_pct = 0;
        if (i_rst_n && !(i_start && !took_beat)) begin
            if (pending_cmds.size() != 0 && $urandom_range(0, 99) >= idle_pct) begin
                i_start <= 1'b1;
                i_cmd <= pending_cmds[0];
            end else begin
                i_start <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial begin
        int   mode;
        int   r;
        t_cmd c;
        value_pool[0] = 32'h8000_0000;
        value_pool[1] = 32'h7FFF_FFFF;
        value_pool[2] = 32'h0000_0000;
        value_pool[3] = 32'hFFFF_FFFF;
        value_pool[4] = 32'h0000_0001;
        for (int i = 5; i < 16; i++) value_pool[i] = $urandom();

        add_cmd(CMD_READ, 0, 32'h1);
        add_cmd(CMD_REMOVE, 0, 32'h0);
        add_cmd(CMD_OVERWRITE, 0, 32'h5);
        add_cmd(CMD_FIND, 0, 32'h0);
        add_cmd(CMD_REVERSE, 0, 32'h0);
        add_cmd(CMD_INSERT, 1, 32'h7);
        add_cmd(CMD_INSERT, 0, 32'h7FFF_FFFF);
        add_cmd(CMD_REVERSE, 0, 32'h0);
        add_cmd(CMD_APPEND, 0, 32'h8000_0000);
        add_cmd(CMD_APPEND, 0, 32'h0000_0000);
        add_cmd(CMD_APPEND, 0, 32'hFFFF_FFFF);
        add_cmd(CMD_INSERT, 64, 32'h9);
        add_cmd(CMD_INSERT, 4, 32'h0000_002A);
        add_cmd(CMD_INSERT, 2, 32'hFFFF_FFFF);
        add_cmd(CMD_FIND, 0, 32'hFFFF_FFFF);
        add_cmd(CMD_FIND, 0, 32'h0000_3039);
        add_cmd(CMD_READ, 5, 32'h0);
        add_cmd(CMD_READ, 6, 32'h0);
        add_cmd(CMD_OVERWRITE, 63, 32'h1);
        add_cmd(CMD_OVERWRITE, 0, 32'hAAAA_AAAA);
        add_cmd(CMD_REVERSE, 0, 32'h0);
        add_cmd(CMD_READ, 0, 32'h0);
        add_cmd(CMD_REMOVE, 5, 32'h0);
        add_cmd(CMD_REMOVE, 0, 32'h0);
        add_cmd(CMD_CLEAR, 0, 32'h0);
        add_cmd(CMD_READ, 0, 32'h0);

        // Episodes: growth toward a full store, mixed traffic on a valid sequence, and noise.
        while (pending_cmds.size() < 1426) begin
            mode = $urandom_range(0, 9);
            repeat ($urandom_range(8, 60)) begin
                if (mode == 9) begin
                    add_cmd(t_cmd'($urandom_range(0, 7)), $urandom_range(0, 64), $urandom());
                end else begin
                    if (mode < 3) begin
                        c = ($urandom_range(0, 3) == 0) ? CMD_INSERT : CMD_APPEND;
                    end else begin
                        r = $urandom_range(0, 99);
                        if (r < 12) c = CMD_APPEND;
                        else if (r < 26) c = CMD_INSERT;
                        else if (r < 40) c = CMD_REMOVE;
                        else if (r < 58) c = CMD_READ;
                        else if (r < 70) c = CMD_OVERWRITE;
                        else if (r < 90) c = CMD_FIND;
                        else if (r < 97) c = CMD_REVERSE;
                        else c = CMD_CLEAR;
                    end
                    add_cmd(c, pick_position(c), pick_value());
                end
            end
        end
        total_items = pending_cmds.size();

        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_cmds.size() != 0 || results_due.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);

        $display("Drove %0d command beats and checked %0d result beats.", n_accepted, n_checked);
        $display("Seen: %0d out-of-range, %0d store-full, %0d find hits.",
                 n_range, n_full, n_hits);
        if (errors == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

[filelist.f]
src/oss_pkg.sv
src/oss_cell.sv
src/oss_reduce.sv
src/ordered_sequence_store_core.sv
src/oss_checker.sv
verif/tb.sv
